// File: design/fat_boot_sector_geometry_assert.svh
// Assertion macros shared by the geometry block.
`ifndef FAT_BOOT_SECTOR_GEOMETRY_ASSERT_SVH
`define FAT_BOOT_SECTOR_GEOMETRY_ASSERT_SVH

// Same-cycle implication.
`define FBSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fat_boot_sector_geometry: same-cycle check failed");

// Next-cycle implication.
`define FBSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fat_boot_sector_geometry: next-cycle check failed");

`endif

// File: design/fbsg_pkg.sv
`default_nettype none

package fbsg_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int POS_W        = $clog2(SECTOR_BYTES);

   localparam logic [7:0] JUMP_SHORT = 8'hEB;
   localparam logic [7:0] JUMP_NEAR  = 8'hE9;

   localparam logic [POS_W-1:0] OFS_BPS      = POS_W'(16'h000B);
   localparam logic [POS_W-1:0] OFS_SPC      = POS_W'(16'h000D);
   localparam logic [POS_W-1:0] OFS_RSVD     = POS_W'(16'h000E);
   localparam logic [POS_W-1:0] OFS_NFAT     = POS_W'(16'h0010);
   localparam logic [POS_W-1:0] OFS_ROOTENT  = POS_W'(16'h0011);
   localparam logic [POS_W-1:0] OFS_TOT16    = POS_W'(16'h0013);
   localparam logic [POS_W-1:0] OFS_FAT16    = POS_W'(16'h0016);
   localparam logic [POS_W-1:0] OFS_TOT32    = POS_W'(16'h0020);
   localparam logic [POS_W-1:0] OFS_FAT32    = POS_W'(16'h0024);
   localparam logic [POS_W-1:0] OFS_ROOTCLUS = POS_W'(16'h002C);
   localparam logic [POS_W-1:0] OFS_PART     = POS_W'(16'h01C6);

   localparam logic [31:0] FAT32_MIN_CLUSTERS = 32'd65525;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_REDIRECT  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [7:0] sector_byte;
      logic       last_byte;
   } fbsg_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] partition_sector;
      logic        fat_is_32;
      logic [15:0] bytes_per_sector;
      logic [7:0]  sectors_per_cluster;
      logic [31:0] fat_start_sector;
      logic [31:0] first_data_sector;
      logic [31:0] root_first_sector;
      logic [31:0] root_dir_sectors;
      logic [31:0] cluster_count;
   } fbsg_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } fbsg_div_req_type;

endpackage

`default_nettype wire

// File: design/fbsg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fbsg_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fbsg_pkg::fbsg_div_req_type div_req,
   output logic                           done,
   output logic [31:0]                    quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] divisor_ff;
   logic [32:0] rem_shift;
   logic [32:0] rem_diff;

   assign rem_shift = {rem_ff, quo_ff[31]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         if (!rem_diff[32]) begin
            rem_ff <= rem_diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: design/fat_boot_sector_geometry.sv
// Sector bytes enter one per cycle on start while busy is low. A byte with last_byte set
// closes the sector: busy then rises. A master boot record, a second miss or a boot
// sector with a zero sector or cluster size is answered from S_CHECK; a valid one goes
// on through S_RDS, S_USED, S_CLUS_GO, S_CLUS, S_ROOT and S_EMIT, using the one
// bit-serial divider twice (root directory sectors, then cluster count). Each answer is
// on rsp_data with rsp_strobe high for one cycle as busy falls; it cannot be stalled.
`default_nettype none

`include "fat_boot_sector_geometry_assert.svh"

module fat_boot_sector_geometry (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire fbsg_pkg::fbsg_req_type req_data,
   output logic                       rsp_strobe,
   output fbsg_pkg::fbsg_rsp_type     rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_RDS, S_USED, S_CLUS_GO, S_CLUS, S_ROOT, S_EMIT
   } state_type;

   state_type state_ff;

   logic [fbsg_pkg::POS_W-1:0] pos_ff;
   logic [fbsg_pkg::POS_W-1:0] pos_in;
   logic [7:0]  jump_ff;
   logic [15:0] bps_ff;
   logic [7:0]  spc_ff;
   logic [15:0] rsvd_ff;
   logic [7:0]  nfat_ff;
   logic [15:0] rootent_ff;
   logic [15:0] tot16_ff;
   logic [15:0] fat16_ff;
   logic [31:0] tot32_ff;
   logic [31:0] fat32_ff;
   logic [31:0] rootclus_ff;
   logic [31:0] part_ff;
   logic        redirect_ff;
   logic [31:0] base_ff;

   logic [31:0] fats_ff;
   logic [31:0] rds_ff;
   logic [31:0] rf_ff;
   logic [31:0] used_ff;
   logic [31:0] rootf16_ff;
   logic [31:0] fstart_ff;
   logic [31:0] fdata_ff;
   logic [31:0] clus_ff;
   logic [31:0] prod_ff;
   logic        strobe_ff;
   fbsg_pkg::fbsg_rsp_type rsp_ff;

   logic        accept;
   logic        boot;
   logic        div_ok;
   logic [31:0] base_use;
   logic [31:0] fsz;
   logic [31:0] tot;
   logic        is32;
   logic        div_done;
   logic [31:0] div_quo;
   fbsg_pkg::fbsg_div_req_type div_req;

   assign accept   = start && !busy;
   assign boot     = (jump_ff == fbsg_pkg::JUMP_SHORT) || (jump_ff == fbsg_pkg::JUMP_NEAR);
   assign div_ok   = (bps_ff != 16'd0) && (spc_ff != 8'd0);
   assign base_use = redirect_ff ? base_ff : 32'd0;
   assign fsz      = (fat16_ff != 16'd0) ? {16'd0, fat16_ff} : fat32_ff;
   assign tot      = (tot16_ff != 16'd0) ? {16'd0, tot16_ff} : tot32_ff;
   assign is32     = clus_ff >= fbsg_pkg::FAT32_MIN_CLUSTERS;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {11'd0, rootent_ff, 5'd0} + {16'd0, bps_ff} - 32'd1;
      div_req.divisor  = {16'd0, bps_ff};
      if (state_ff == S_CHECK) begin
         div_req.start = boot && div_ok;
      end else if (state_ff == S_CLUS_GO) begin
         div_req.start    = 1'b1;
         div_req.dividend = tot - used_ff;
         div_req.divisor  = {24'd0, spc_ff};
      end
   end

   fbsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // wrap at the sector size, restart after the final byte
   always_comb begin
      if (req_data.last_byte || pos_ff == fbsg_pkg::POS_W'(fbsg_pkg::SECTOR_BYTES - 1)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         jump_ff     <= '0;
         bps_ff      <= '0;
         spc_ff      <= '0;
         rsvd_ff     <= '0;
         nfat_ff     <= '0;
         rootent_ff  <= '0;
         tot16_ff    <= '0;
         fat16_ff    <= '0;
         tot32_ff    <= '0;
         fat32_ff    <= '0;
         rootclus_ff <= '0;
         part_ff     <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         if (pos_ff == '0) jump_ff <= req_data.sector_byte;
         if (pos_ff == fbsg_pkg::OFS_SPC) spc_ff <= req_data.sector_byte;
         if (pos_ff == fbsg_pkg::OFS_NFAT) nfat_ff <= req_data.sector_byte;
         for (int i = 0; i < 2; i++) begin
            if (pos_ff == fbsg_pkg::OFS_BPS + fbsg_pkg::POS_W'(i))
               bps_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_RSVD + fbsg_pkg::POS_W'(i))
               rsvd_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_ROOTENT + fbsg_pkg::POS_W'(i))
               rootent_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_TOT16 + fbsg_pkg::POS_W'(i))
               tot16_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_FAT16 + fbsg_pkg::POS_W'(i))
               fat16_ff[i*8 +: 8] <= req_data.sector_byte;
         end
         for (int i = 0; i < 4; i++) begin
            if (pos_ff == fbsg_pkg::OFS_TOT32 + fbsg_pkg::POS_W'(i))
               tot32_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_FAT32 + fbsg_pkg::POS_W'(i))
               fat32_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_ROOTCLUS + fbsg_pkg::POS_W'(i))
               rootclus_ff[i*8 +: 8] <= req_data.sector_byte;
            if (pos_ff == fbsg_pkg::OFS_PART + fbsg_pkg::POS_W'(i))
               part_ff[i*8 +: 8] <= req_data.sector_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         redirect_ff <= 1'b0;
         base_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && req_data.last_byte) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               rsp_ff  <= '0;
               fats_ff <= {24'd0, nfat_ff} * fsz;
               if (!boot) begin
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
                  if (redirect_ff) begin
                     redirect_ff   <= 1'b0;
                     base_ff       <= '0;
                     rsp_ff.status <= fbsg_pkg::STATUS_NOT_FOUND;
                  end else begin
                     redirect_ff             <= 1'b1;
                     base_ff                 <= part_ff;
                     rsp_ff.status           <= fbsg_pkg::STATUS_REDIRECT;
                     rsp_ff.partition_sector <= part_ff;
                  end
               end else begin
                  redirect_ff <= 1'b0;
                  base_ff     <= base_use;
                  if (!div_ok) begin
                     strobe_ff     <= 1'b1;
                     rsp_ff.status <= fbsg_pkg::STATUS_NOT_FOUND;
                     state_ff      <= S_IDLE;
                  end else begin
                     state_ff <= S_RDS;
                  end
               end
            end
            S_RDS: begin
               if (div_done) begin
                  rds_ff   <= div_quo;
                  rf_ff    <= {16'd0, rsvd_ff} + fats_ff;
                  state_ff <= S_USED;
               end
            end
            S_USED: begin
               used_ff    <= rf_ff + rds_ff;
               rootf16_ff <= rf_ff + base_ff;
               fstart_ff  <= {16'd0, rsvd_ff} + base_ff;
               state_ff   <= S_CLUS_GO;
            end
            S_CLUS_GO: begin
               fdata_ff <= used_ff + base_ff;
               state_ff <= S_CLUS;
            end
            S_CLUS: begin
               if (div_done) begin
                  clus_ff  <= div_quo;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               prod_ff  <= (rootclus_ff - 32'd2) * {24'd0, spc_ff};
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               rsp_ff.status              <= fbsg_pkg::STATUS_OK;
               rsp_ff.partition_sector    <= base_ff;
               rsp_ff.fat_is_32           <= is32;
               rsp_ff.bytes_per_sector    <= bps_ff;
               rsp_ff.sectors_per_cluster <= spc_ff;
               rsp_ff.fat_start_sector    <= fstart_ff;
               rsp_ff.first_data_sector   <= fdata_ff;
               rsp_ff.root_first_sector   <= is32 ? (prod_ff + fdata_ff) : rootf16_ff;
               rsp_ff.root_dir_sectors    <= rds_ff;
               rsp_ff.cluster_count       <= clus_ff;
               strobe_ff                  <= 1'b1;
               state_ff                   <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `FBSG_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `FBSG_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `FBSG_ASSERT_NEXT(a_last_goes_busy, clock, reset, accept && req_data.last_byte, busy)
   `FBSG_ASSERT_NOW(a_redirect_marks, clock, reset,
      rsp_strobe && rsp_data.status == fbsg_pkg::STATUS_REDIRECT, redirect_ff)

endmodule

`default_nettype wire

// File: tb/fat_boot_sector_geometry_tb.sv
`timescale 1ns / 1ps

module fat_boot_sector_geometry_tb;
   import fbsg_pkg::*;

   localparam int RANDOM_BYTES   = 550;
   localparam int RANDOM_SECTORS = 60;
   localparam int QUIET_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct packed {
      logic [7:0]  jump;
      logic [15:0] bps;
      logic [7:0]  spc;
      logic [15:0] rsvd;
      logic [7:0]  nfat;
      logic [15:0] rootent;
      logic [15:0] tot16;
      logic [15:0] fat16;
      logic [31:0] tot32;
      logic [31:0] fat32;
      logic [31:0] rootclus;
      logic [31:0] part;
      int          len;
      bit          typed;
      logic [1:0]  status;
      logic [31:0] part_out;
   } sector_row_type;

   typedef struct {
      bit           typed;
      fbsg_rsp_type rsp;
   } typed_answer_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         start      = 1'b0;
   fbsg_req_type req_data   = '0;
   logic         busy;
   logic         rsp_strobe;
   fbsg_rsp_type rsp_data;

   // geometry tracked from the accepted bytes
   logic [8:0]  byte_pos      = '0;
   logic [7:0]  jump_op       = '0;
   logic [15:0] bps_f         = '0;
   logic [7:0]  spc_f         = '0;
   logic [15:0] rsvd_f        = '0;
   logic [7:0]  nfat_f        = '0;
   logic [15:0] rootent_f     = '0;
   logic [15:0] tot16_f       = '0;
   logic [15:0] fat16_f       = '0;
   logic [31:0] tot32_f       = '0;
   logic [31:0] fat32_f       = '0;
   logic [31:0] rootclus_f    = '0;
   logic [31:0] mbr_part      = '0;
   logic        redirect_wait = 1'b0;
   logic [31:0] part_base     = '0;

   fbsg_rsp_type     expected_geometry[$];
   typed_answer_type typed_geometry[$];

   logic [7:0] sector_img [0:2*SECTOR_BYTES-1];

   int mismatches     = 0;
   int bytes_sent     = 0;
   int sectors_sent   = 0;
   int burst_left     = 0;
   int quiet_cycles   = 0;
   int geometry_count = 0;
   int redirect_count = 0;
   int missing_count  = 0;

   sector_row_type directed_rows [0:16] = '{
      // single non-boot byte straight out of reset, then a second miss
      '{8'h00, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 1, 1'b1, STATUS_REDIRECT, 32'd0},
      '{8'h00, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 1, 1'b1, STATUS_NOT_FOUND, 32'd0},
      '{8'hFA, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'h0000_0800, 512, 1'b1, STATUS_REDIRECT, 32'h0000_0800},
      '{8'hEB, 16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd0, 16'd250,
        32'd250000, 32'd0, 32'd0, 32'd0, 512, 1'b0, STATUS_OK, 32'd0},
      '{8'hE9, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 16'd0,
        32'd2000000, 32'd2000, 32'd2, 32'd0, 512, 1'b0, STATUS_OK, 32'd0},
      // cluster count right at the FAT32 threshold, then one below it
      '{8'hEB, 16'd512, 8'd1, 16'd1, 8'd1, 16'd0, 16'd0, 16'd10,
        32'd65536, 32'd0, 32'd5, 32'd0, 64, 1'b0, STATUS_OK, 32'd0},
      '{8'hEB, 16'd512, 8'd1, 16'd1, 8'd1, 16'd0, 16'd65535, 16'd10,
        32'd65536, 32'd0, 32'd5, 32'd0, 64, 1'b0, STATUS_OK, 32'd0},
      '{8'hEB, 16'd4096, 8'd128, 16'd16, 8'd2, 16'd1024, 16'd40000, 16'd0,
        32'd0, 32'd300, 32'd7, 32'd0, 48, 1'b0, STATUS_OK, 32'd0},
      '{8'hEB, 16'd0, 8'd4, 16'd4, 8'd2, 16'd512, 16'd0, 16'd250,
        32'd250000, 32'd0, 32'd0, 32'd0, 48, 1'b1, STATUS_NOT_FOUND, 32'd0},
      '{8'hE9, 16'd512, 8'd0, 16'd4, 8'd2, 16'd512, 16'd0, 16'd250,
        32'd250000, 32'd0, 32'd0, 32'd0, 48, 1'b1, STATUS_NOT_FOUND, 32'd0},
      '{8'h33, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 512, 1'b1, STATUS_REDIRECT, 32'hFFFF_FFFF},
      '{8'hEA, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 512, 1'b1, STATUS_NOT_FOUND, 32'd0},
      '{8'hE8, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'hFFFF_FFF0, 512, 1'b1, STATUS_REDIRECT, 32'hFFFF_FFF0},
      // every field at its maximum on top of a huge partition base
      '{8'hEB, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 512, 1'b0,
        STATUS_OK, 32'd0},
      '{8'hE9, 16'd512, 8'd64, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 48, 1'b0, STATUS_OK, 32'd0},
      '{8'hEB, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 1, 1'b0, STATUS_OK, 32'd0},
      '{8'hEB, 16'd512, 8'd2, 16'd2, 8'd2, 16'd224, 16'd2880, 16'd9,
        32'd0, 32'd0, 32'd0, 32'd0, 600, 1'b0, STATUS_OK, 32'd0}
   };

   fat_boot_sector_geometry i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] lane_merge(logic [31:0] cur, int pos, int base, int n,
                                              logic [7:0] value);
      if (pos >= base && pos < base + n) cur[(pos - base) * 8 +: 8] = value;
      return cur;
   endfunction

   // mostly the typical value, sometimes zero, all ones or anything
   function automatic logic [31:0] skew_field(logic [31:0] typical);
      case ($urandom_range(0, 11))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom();
         default: return typical;
      endcase
   endfunction

   task automatic advance_geometry(input fbsg_req_type rq);
      logic [31:0]      bps, spc, rds, fsz, tot, fats, clus, fstart, fdata;
      int               pos;
      fbsg_rsp_type     ans;
      typed_answer_type note;
      pos        = int'(byte_pos);
      jump_op    = 8'(lane_merge(32'(jump_op), pos, 0, 1, rq.sector_byte));
      bps_f      = 16'(lane_merge(32'(bps_f), pos, int'(OFS_BPS), 2, rq.sector_byte));
      spc_f      = 8'(lane_merge(32'(spc_f), pos, int'(OFS_SPC), 1, rq.sector_byte));
      rsvd_f     = 16'(lane_merge(32'(rsvd_f), pos, int'(OFS_RSVD), 2, rq.sector_byte));
      nfat_f     = 8'(lane_merge(32'(nfat_f), pos, int'(OFS_NFAT), 1, rq.sector_byte));
      rootent_f  = 16'(lane_merge(32'(rootent_f), pos, int'(OFS_ROOTENT), 2, rq.sector_byte));
      tot16_f    = 16'(lane_merge(32'(tot16_f), pos, int'(OFS_TOT16), 2, rq.sector_byte));
      fat16_f    = 16'(lane_merge(32'(fat16_f), pos, int'(OFS_FAT16), 2, rq.sector_byte));
      tot32_f    = lane_merge(tot32_f, pos, int'(OFS_TOT32), 4, rq.sector_byte);
      fat32_f    = lane_merge(fat32_f, pos, int'(OFS_FAT32), 4, rq.sector_byte);
      rootclus_f = lane_merge(rootclus_f, pos, int'(OFS_ROOTCLUS), 4, rq.sector_byte);
      mbr_part   = lane_merge(mbr_part, pos, int'(OFS_PART), 4, rq.sector_byte);
      if (!rq.last_byte) begin
         byte_pos = (byte_pos == 9'(SECTOR_BYTES - 1)) ? '0 : byte_pos + 9'd1;
         return;
      end
      byte_pos = '0;
      ans      = '0;
      // a sector that ends with no redirect outstanding is sector 0
      if (!redirect_wait) part_base = '0;
      if (jump_op != JUMP_SHORT && jump_op != JUMP_NEAR) begin
         if (redirect_wait) begin
            redirect_wait = 1'b0;
            ans.status    = STATUS_NOT_FOUND;
         end else begin
            redirect_wait        = 1'b1;
            part_base            = mbr_part;
            ans.status           = STATUS_REDIRECT;
            ans.partition_sector = mbr_part;
         end
      end else begin
         redirect_wait = 1'b0;
         bps = 32'(bps_f);
         spc = 32'(spc_f);
         if (bps == 32'd0 || spc == 32'd0) begin
            ans.status = STATUS_NOT_FOUND;
         end else begin
            rds    = ((32'(rootent_f) << 5) + bps - 32'd1) / bps;
            fsz    = (fat16_f != '0) ? 32'(fat16_f) : fat32_f;
            tot    = (tot16_f != '0) ? 32'(tot16_f) : tot32_f;
            fats   = 32'(nfat_f) * fsz;
            clus   = (tot - (32'(rsvd_f) + fats + rds)) / spc;
            fstart = 32'(rsvd_f) + part_base;
            fdata  = fstart + fats + rds;
            ans.status              = STATUS_OK;
            ans.partition_sector    = part_base;
            ans.fat_is_32           = (clus >= FAT32_MIN_CLUSTERS);
            ans.bytes_per_sector    = bps_f;
            ans.sectors_per_cluster = spc_f;
            ans.fat_start_sector    = fstart;
            ans.first_data_sector   = fdata;
            ans.root_first_sector   = ans.fat_is_32 ? (rootclus_f - 32'd2) * spc + fdata
                                                    : 32'(rsvd_f) + fats + part_base;
            ans.root_dir_sectors    = rds;
            ans.cluster_count       = clus;
         end
      end
      if (typed_geometry.size() != 0) begin
         note = typed_geometry.pop_front();
         if (note.typed) ans = note.rsp;
      end
      expected_geometry.push_back(ans);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_geometry(input fbsg_rsp_type got);
      fbsg_rsp_type want;
      if (expected_geometry.size() == 0) begin
         $error("status: expected no result, got 0x%0h", got.status);
         mismatches++;
         return;
      end
      want = expected_geometry.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("partition_sector", want.partition_sector, got.partition_sector);
      compare_field("fat_is_32", 32'(want.fat_is_32), 32'(got.fat_is_32));
      compare_field("bytes_per_sector", 32'(want.bytes_per_sector),
                    32'(got.bytes_per_sector));
      compare_field("sectors_per_cluster", 32'(want.sectors_per_cluster),
                    32'(got.sectors_per_cluster));
      compare_field("fat_start_sector", want.fat_start_sector, got.fat_start_sector);
      compare_field("first_data_sector", want.first_data_sector, got.first_data_sector);
      compare_field("root_first_sector", want.root_first_sector, got.root_first_sector);
      compare_field("root_dir_sectors", want.root_dir_sectors, got.root_dir_sectors);
      compare_field("cluster_count", want.cluster_count, got.cluster_count);
      case (want.status)
         STATUS_OK:       geometry_count++;
         STATUS_REDIRECT: redirect_count++;
         default:         missing_count++;
      endcase
   endtask

   task automatic put_le(input int ofs, input logic [31:0] value, input int n);
      for (int k = 0; k < n; k++) sector_img[ofs + k] = value[8 * k +: 8];
   endtask

   // noisy: random filler, and the bytes past the sector end mix fresh and repeated
   task automatic write_sector_image(input sector_row_type row, input bit noisy);
      for (int i = 0; i < 2 * SECTOR_BYTES; i++)
         sector_img[i] = noisy ? 8'($urandom()) : 8'h00;
      sector_img[0] = row.jump;
      put_le(int'(OFS_BPS), 32'(row.bps), 2);
      put_le(int'(OFS_SPC), 32'(row.spc), 1);
      put_le(int'(OFS_RSVD), 32'(row.rsvd), 2);
      put_le(int'(OFS_NFAT), 32'(row.nfat), 1);
      put_le(int'(OFS_ROOTENT), 32'(row.rootent), 2);
      put_le(int'(OFS_TOT16), 32'(row.tot16), 2);
      put_le(int'(OFS_FAT16), 32'(row.fat16), 2);
      put_le(int'(OFS_TOT32), row.tot32, 4);
      put_le(int'(OFS_FAT32), row.fat32, 4);
      put_le(int'(OFS_ROOTCLUS), row.rootclus, 4);
      put_le(int'(OFS_PART), row.part, 4);
      for (int i = SECTOR_BYTES; i < 2 * SECTOR_BYTES; i++)
         if (!noisy || $urandom_range(0, 1) == 0) sector_img[i] = sector_img[i - SECTOR_BYTES];
   endtask

   task automatic send_request(input logic [7:0] value, input logic closes);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= '{sector_byte: value, last_byte: closes};
      do @(posedge clock); while (busy);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_sector(input sector_row_type row);
      typed_answer_type note;
      note.typed                = row.typed;
      note.rsp                  = '0;
      note.rsp.status           = row.status;
      note.rsp.partition_sector = row.part_out;
      typed_geometry.push_back(note);
      for (int i = 0; i < row.len; i++) send_request(sector_img[i], i == row.len - 1);
      sectors_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) check_geometry(rsp_data);
         if (start && !busy) advance_geometry(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("fat_boot_sector_geometry test failed");
         $finish;
      end
   end

   initial begin
      sector_row_type row;
      int             directed_bytes;
      int             directed_sectors;
      int             pick;
      bit             expect_boot;
      bit             fat32_like;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         write_sector_image(directed_rows[r], 1'b0);
         send_sector(directed_rows[r]);
      end
      directed_bytes   = bytes_sent;
      directed_sectors = sectors_sent;

      expect_boot = 1'b0;
      while (bytes_sent - directed_bytes < RANDOM_BYTES ||
             sectors_sent - directed_sectors < RANDOM_SECTORS) begin
         fat32_like   = $urandom_range(0, 1);
         row          = '0;
         row.bps      = 16'(skew_field(32'd512 << $urandom_range(0, 3)));
         row.spc      = 8'(skew_field(32'd1 << $urandom_range(0, 7)));
         row.rsvd     = 16'(skew_field($urandom_range(1, 64)));
         row.nfat     = 8'(skew_field($urandom_range(1, 2)));
         row.rootent  = 16'(skew_field(fat32_like ? 0 : 512));
         row.tot16    = 16'(skew_field(fat32_like ? 0 : $urandom_range(1000, 65535)));
         row.fat16    = 16'(skew_field(fat32_like ? 0 : $urandom_range(1, 256)));
         row.tot32    = skew_field(fat32_like ? $urandom_range(600000, 20000000)
                                              : $urandom_range(0, 4000000));
         row.fat32    = skew_field($urandom_range(100, 20000));
         row.rootclus = skew_field($urandom_range(2, 100));
         row.part     = $urandom();
         pick         = $urandom_range(0, 99);
         // after a master boot record, mostly follow up with the partition's boot sector
         if (expect_boot ? ($urandom_range(0, 6) != 0) : (pick < 55)) begin
            row.jump = $urandom_range(0, 1) ? JUMP_SHORT : JUMP_NEAR;
            case ($urandom_range(0, 9))
               0:       row.len = $urandom_range(1, int'(OFS_ROOTCLUS) + 3);
               1:       row.len = SECTOR_BYTES;
               2:       row.len = $urandom_range(SECTOR_BYTES + 1, 2 * SECTOR_BYTES - 1);
               default: row.len = $urandom_range(int'(OFS_ROOTCLUS) + 4, 80);
            endcase
            expect_boot = 1'b0;
         end else if (pick < 80 && !expect_boot) begin
            do row.jump = 8'($urandom()); while (row.jump == JUMP_SHORT || row.jump == JUMP_NEAR);
            row.part = skew_field($urandom_range(0, 1 << 24));
            case ($urandom_range(0, 4))
               0:       row.len = $urandom_range(int'(OFS_PART) + 4, SECTOR_BYTES - 1);
               1:       row.len = $urandom_range(1, 16);
               default: row.len = SECTOR_BYTES;
            endcase
            expect_boot = 1'b1;
         end else begin
            row.jump    = 8'($urandom());
            row.len     = $urandom_range(1, 48);
            expect_boot = 1'b0;
         end
         write_sector_image(row, 1'b1);
         send_sector(row);
      end
      start <= 1'b0;

      while (expected_geometry.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_geometry.size() != 0) begin
         $error("status: expected %0d more results, got none", expected_geometry.size());
         mismatches++;
      end

      $display("Streamed %0d sector bytes in %0d sectors, %0d of them hand-built.",
               bytes_sent, sectors_sent, directed_sectors);
      $display("Checked %0d geometry, %0d redirect and %0d not-found answers.",
               geometry_count, redirect_count, missing_count);
      if (mismatches == 0) begin
         $display("fat_boot_sector_geometry test passed");
      end else begin
         $display("fat_boot_sector_geometry test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/fbsg_pkg.sv
design/fbsg_div.sv
design/fat_boot_sector_geometry.sv
tb/fat_boot_sector_geometry_tb.sv
